>>> rtl/ata_pkg.sv
// ----------------------------------------------------------------------------
// ata_pkg
// Shared widths, constants and the arctangent table of the tilt angle block.
// ----------------------------------------------------------------------------
package ata_pkg;

    localparam int SAMPLE_WIDTH     = 16;
    localparam int ANGLE_ITERATIONS = 16;

    localparam int GAIN_W  = 16;
    localparam int PROD_W  = 32;
    localparam int ABS_W   = 31;
    localparam int SQ_W    = 62;
    localparam int RAD_W   = 64;
    localparam int ROOT_W  = 32;
    localparam int SQRT_STAGES = 32;
    localparam int CIN_W   = 33;
    localparam int CW      = 35;
    localparam int AW      = 35;
    localparam int MAG_W   = 22;
    localparam int PITCH_W = 16;
    localparam int ROLL_W  = 17;
    localparam int RND_W   = AW - 16;
    localparam int TABLE_LEN = 24;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd2511;
    localparam logic [MAG_W-1:0]  MAG_MAX    = 22'd4194303;
    localparam logic [RND_W-1:0]  PITCH_LIM  = RND_W'(23040);
    localparam logic [RND_W-1:0]  ROLL_LIM   = RND_W'(46080);

    localparam logic signed [AW-1:0] DEG90  = AW'(64'sd1509949440);
    localparam logic signed [AW-1:0] DEG180 = AW'(64'sd3019898880);

    localparam logic signed [AW-1:0] ATAN_TAB [TABLE_LEN] = '{
        AW'(754974720), AW'(445687602), AW'(235489088), AW'(119537938),
        AW'(60000934),  AW'(30029717),  AW'(15018523),  AW'(7509720),
        AW'(3754917),   AW'(1877466),   AW'(938734),    AW'(469367),
        AW'(234684),    AW'(117342),    AW'(58671),     AW'(29335),
        AW'(14668),     AW'(7334),      AW'(3667),      AW'(1833),
        AW'(917),       AW'(458),       AW'(229),       AW'(115)
    };

endpackage

>>> rtl/accel_tilt_angles.sv
// ----------------------------------------------------------------------------
// accel_tilt_angles
// Magnitude, pitch and roll of a three-axis accelerometer sample.
// ----------------------------------------------------------------------------
// Fully pipelined: one sample item is taken every cycle while the result side
// is not stalled; its result passes through 3 scaling, squaring and summing
// stages, 32 square root stages, one CORDIC setup stage plus one stage per
// angle iteration, and one rounding stage. A stall on the result side freezes
// the whole pipeline; sample_stall is high exactly while a result is held
// stalled. A gain write takes effect for items accepted after it.
module accel_tilt_angles
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 gain_we,
    input  logic [ata_pkg::GAIN_W-1:0]           gain_wdata,
    input  logic                                 sample_valid,
    output logic                                 sample_stall,
    input  logic signed [15:0]                   accel_x,
    input  logic signed [15:0]                   accel_y,
    input  logic signed [15:0]                   accel_z,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic [ata_pkg::MAG_W-1:0]            magnitude,
    output logic signed [ata_pkg::PITCH_W-1:0]   pitch_deg,
    output logic signed [ata_pkg::ROLL_W-1:0]    roll_deg
);

    localparam int SW   = ata_pkg::SAMPLE_WIDTH;
    localparam int DLY  = 2 + ata_pkg::SQRT_STAGES;
    localparam int CLAT = ata_pkg::ANGLE_ITERATIONS + 1;
    localparam int LAT  = 3 + ata_pkg::SQRT_STAGES + CLAT + 1;

    logic                             en;
    logic [ata_pkg::GAIN_W-1:0]       gain_reg;
    logic [LAT-1:0]                   vld_reg;

    logic signed [ata_pkg::PROD_W-1:0] sx_reg, sy_reg, sz_reg;
    logic [ata_pkg::SQ_W-1:0]          ax2_reg, ay2_reg, az2_reg;
    logic [ata_pkg::RAD_W-1:0]         syz_reg, sum_reg;
    logic [ata_pkg::ABS_W-1:0]         ax, ay, az;

    logic signed [ata_pkg::PROD_W-1:0] dx_reg [DLY];
    logic signed [ata_pkg::PROD_W-1:0] dy_reg [DLY];
    logic signed [ata_pkg::PROD_W-1:0] dz_reg [DLY];

    logic [ata_pkg::ROOT_W-1:0]  root_yz, root_all;
    logic [ata_pkg::ROOT_W:0]    mag_wide;
    logic [ata_pkg::MAG_W-1:0]   mag_sat;
    logic [ata_pkg::MAG_W-1:0]   dm_reg [CLAT];

    logic signed [ata_pkg::AW-1:0]    pitch_acc, roll_acc;
    logic signed [ata_pkg::RND_W-1:0] pitch_rnd, roll_rnd;

    logic [ata_pkg::MAG_W-1:0]          magnitude_reg;
    logic signed [ata_pkg::PITCH_W-1:0] pitch_reg;
    logic signed [ata_pkg::ROLL_W-1:0]  roll_reg;

    function automatic logic signed [ata_pkg::RND_W-1:0] round_q8
    (
        input logic signed [ata_pkg::AW-1:0] a,
        input logic [ata_pkg::RND_W-1:0]     lim
    );
        logic [ata_pkg::AW-1:0]    mag;
        logic [ata_pkg::RND_W-1:0] r;
        mag = (a < 0) ? ata_pkg::AW'(-a) : ata_pkg::AW'(a);
        r = ata_pkg::RND_W'((mag + ata_pkg::AW'(32768)) >> 16);
        if (r > lim)
        begin
            r = lim;
        end
        return (a < 0) ? -$signed(r) : $signed(r);
    endfunction

    assign en           = !(result_valid && result_stall);
    assign sample_stall = !en;
    assign result_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= ata_pkg::GAIN_RESET;
            vld_reg  <= '0;
        end
        else
        begin
            if (gain_we)
            begin
                gain_reg <= gain_wdata;
            end
            if (en)
            begin
                vld_reg <= {vld_reg[LAT-2:0], sample_valid};
            end
        end
    end

    // Scale
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg <= ata_pkg::PROD_W'($signed(accel_x[SW-1:0]) * $signed({1'b0, gain_reg}));
            sy_reg <= ata_pkg::PROD_W'($signed(accel_y[SW-1:0]) * $signed({1'b0, gain_reg}));
            sz_reg <= ata_pkg::PROD_W'($signed(accel_z[SW-1:0]) * $signed({1'b0, gain_reg}));
        end
    end

    // Square
    always_comb
    begin
        ax = ata_pkg::ABS_W'((sx_reg < 0) ? -sx_reg : sx_reg);
        ay = ata_pkg::ABS_W'((sy_reg < 0) ? -sy_reg : sy_reg);
        az = ata_pkg::ABS_W'((sz_reg < 0) ? -sz_reg : sz_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax2_reg <= ata_pkg::SQ_W'(ax) * ata_pkg::SQ_W'(ax);
            ay2_reg <= ata_pkg::SQ_W'(ay) * ata_pkg::SQ_W'(ay);
            az2_reg <= ata_pkg::SQ_W'(az) * ata_pkg::SQ_W'(az);
            syz_reg <= ata_pkg::RAD_W'(ay2_reg) + ata_pkg::RAD_W'(az2_reg);
            sum_reg <= ata_pkg::RAD_W'(ay2_reg) + ata_pkg::RAD_W'(az2_reg)
                     + ata_pkg::RAD_W'(ax2_reg);
        end
    end

    // Hold the scaled axes until the roots arrive
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg[0] <= sx_reg;
            dy_reg[0] <= sy_reg;
            dz_reg[0] <= sz_reg;
            for (int k = 1; k < DLY; k++)
            begin
                dx_reg[k] <= dx_reg[k-1];
                dy_reg[k] <= dy_reg[k-1];
                dz_reg[k] <= dz_reg[k-1];
            end
        end
    end

    ata_isqrt u_sqrt_yz
    (
        .clk      (clk),
        .en       (en),
        .radicand (syz_reg),
        .root     (root_yz)
    );

    ata_isqrt u_sqrt_all
    (
        .clk      (clk),
        .en       (en),
        .radicand (sum_reg),
        .root     (root_all)
    );

    ata_cordic u_pitch
    (
        .clk   (clk),
        .en    (en),
        .y_in  (ata_pkg::CIN_W'(dx_reg[DLY-1])),
        .x_in  ($signed({1'b0, root_yz})),
        .angle (pitch_acc)
    );

    ata_cordic u_roll
    (
        .clk   (clk),
        .en    (en),
        .y_in  (ata_pkg::CIN_W'(dy_reg[DLY-1])),
        .x_in  (ata_pkg::CIN_W'(dz_reg[DLY-1])),
        .angle (roll_acc)
    );

    always_comb
    begin
        mag_wide = ((ata_pkg::ROOT_W+1)'(root_all) + (ata_pkg::ROOT_W+1)'(128)) >> 8;
        mag_sat  = (mag_wide > (ata_pkg::ROOT_W+1)'(ata_pkg::MAG_MAX))
                 ? ata_pkg::MAG_MAX : mag_wide[ata_pkg::MAG_W-1:0];
        pitch_rnd = round_q8(pitch_acc, ata_pkg::PITCH_LIM);
        roll_rnd  = round_q8(roll_acc, ata_pkg::ROLL_LIM);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dm_reg[0] <= mag_sat;
            for (int k = 1; k < CLAT; k++)
            begin
                dm_reg[k] <= dm_reg[k-1];
            end
            magnitude_reg <= dm_reg[CLAT-1];
            pitch_reg     <= pitch_rnd[ata_pkg::PITCH_W-1:0];
            roll_reg      <= roll_rnd[ata_pkg::ROLL_W-1:0];
        end
    end

    assign magnitude = magnitude_reg;
    assign pitch_deg = pitch_reg;
    assign roll_deg  = roll_reg;

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_stall) |=> vld_reg[0])
        else $error("accepted item did not enter the pipeline");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> $stable(vld_reg))
        else $error("pipeline moved while the result was stalled");

    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (pitch_deg >= -16'sd23040 && pitch_deg <= 16'sd23040))
        else $error("pitch out of range");

    a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (roll_deg >= -17'sd46080 && roll_deg <= 17'sd46080))
        else $error("roll out of range");

endmodule

>>> rtl/ata_isqrt.sv
// ----------------------------------------------------------------------------
// ata_isqrt
// Pipelined floor integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module ata_isqrt
(
    input  logic                         clk,
    input  logic                         en,
    input  logic [ata_pkg::RAD_W-1:0]    radicand,
    output logic [ata_pkg::ROOT_W-1:0]   root
);

    logic [ata_pkg::RAD_W-1:0] n_reg [ata_pkg::SQRT_STAGES];
    logic [ata_pkg::RAD_W-1:0] r_reg [ata_pkg::SQRT_STAGES];

    for (genvar i = 0; i < ata_pkg::SQRT_STAGES; i++)
    begin : g_stage
        localparam logic [ata_pkg::RAD_W-1:0] BIT =
            ata_pkg::RAD_W'(1) << (ata_pkg::RAD_W - 2 - 2 * i);
        logic [ata_pkg::RAD_W-1:0] n_in;
        logic [ata_pkg::RAD_W-1:0] r_in;
        logic [ata_pkg::RAD_W-1:0] trial;
        logic [ata_pkg::RAD_W-1:0] n_next;
        logic [ata_pkg::RAD_W-1:0] r_next;

        if (i == 0)
        begin : g_first
            assign n_in = radicand;
            assign r_in = '0;
        end
        else
        begin : g_rest
            assign n_in = n_reg[i-1];
            assign r_in = r_reg[i-1];
        end

        always_comb
        begin
            trial = r_in + BIT;
            if (n_in >= trial)
            begin
                n_next = n_in - trial;
                r_next = (r_in >> 1) + BIT;
            end
            else
            begin
                n_next = n_in;
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[i] <= n_next;
                r_reg[i] <= r_next;
            end
        end
    end

    assign root = r_reg[ata_pkg::SQRT_STAGES-1][ata_pkg::ROOT_W-1:0];

endmodule

>>> rtl/ata_cordic.sv
// ----------------------------------------------------------------------------
// ata_cordic
// Pipelined vectoring CORDIC: atan2(y, x) in degrees with 24 fraction bits.
// ----------------------------------------------------------------------------
module ata_cordic
(
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [ata_pkg::CIN_W-1:0]   y_in,
    input  logic signed [ata_pkg::CIN_W-1:0]   x_in,
    output logic signed [ata_pkg::AW-1:0]      angle
);

    localparam int N = ata_pkg::ANGLE_ITERATIONS;

    logic signed [ata_pkg::CW-1:0] x_reg   [N+1];
    logic signed [ata_pkg::CW-1:0] y_reg   [N+1];
    logic signed [ata_pkg::AW-1:0] acc_reg [N+1];

    logic signed [ata_pkg::CW-1:0] xe;
    logic signed [ata_pkg::CW-1:0] ye;
    logic signed [ata_pkg::CW-1:0] x0_next;
    logic signed [ata_pkg::CW-1:0] y0_next;
    logic signed [ata_pkg::AW-1:0] acc0_next;

    // Fold special cases and the left half plane in front of the iterations
    always_comb
    begin
        xe = ata_pkg::CW'(x_in);
        ye = ata_pkg::CW'(y_in);
        x0_next   = xe;
        y0_next   = ye;
        acc0_next = '0;
        priority if (ye == '0)
        begin
            y0_next   = '0;
            acc0_next = (xe < 0) ? ata_pkg::DEG180 : '0;
        end
        else if (xe == '0)
        begin
            y0_next   = '0;
            acc0_next = (ye > 0) ? ata_pkg::DEG90 : -ata_pkg::DEG90;
        end
        else if (xe < 0)
        begin
            if (ye > 0)
            begin
                x0_next   = ye;
                y0_next   = -xe;
                acc0_next = ata_pkg::DEG90;
            end
            else
            begin
                x0_next   = -ye;
                y0_next   = xe;
                acc0_next = -ata_pkg::DEG90;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= x0_next;
            y_reg[0]   <= y0_next;
            acc_reg[0] <= acc0_next;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_iter
        logic signed [ata_pkg::CW-1:0] dx;
        logic signed [ata_pkg::CW-1:0] dy;
        logic signed [ata_pkg::CW-1:0] x_next;
        logic signed [ata_pkg::CW-1:0] y_next;
        logic signed [ata_pkg::AW-1:0] acc_next;

        always_comb
        begin
            dx = y_reg[i] >>> i;
            dy = x_reg[i] >>> i;
            x_next   = x_reg[i];
            y_next   = y_reg[i];
            acc_next = acc_reg[i];
            if (y_reg[i] > 0)
            begin
                x_next   = x_reg[i] + dx;
                y_next   = y_reg[i] - dy;
                acc_next = acc_reg[i] + ata_pkg::ATAN_TAB[i];
            end
            else if (y_reg[i] < 0)
            begin
                x_next   = x_reg[i] - dx;
                y_next   = y_reg[i] + dy;
                acc_next = acc_reg[i] - ata_pkg::ATAN_TAB[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1]   <= x_next;
                y_reg[i+1]   <= y_next;
                acc_reg[i+1] <= acc_next;
            end
        end
    end

    assign angle = acc_reg[N];

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// Tilt angle block testbench
// Drives raw accelerometer samples under several gain settings, with random
// idle bursts on both sides, and checks magnitude, pitch and roll of every
// result against a behavioral prediction of the fixed-point datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic [ata_pkg::MAG_W-1:0]          mag;
        logic signed [ata_pkg::PITCH_W-1:0] pitch;
        logic signed [ata_pkg::ROLL_W-1:0]  roll;
    } tilt_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 gain_we = 1'b0;
    logic [ata_pkg::GAIN_W-1:0]           gain_wdata = '0;
    logic                                 sample_valid = 1'b0;
    logic                                 sample_stall;
    logic signed [15:0]                   accel_x = '0;
    logic signed [15:0]                   accel_y = '0;
    logic signed [15:0]                   accel_z = '0;
    logic                                 result_valid;
    logic                                 result_stall = 1'b0;
    logic [ata_pkg::MAG_W-1:0]            magnitude;
    logic signed [ata_pkg::PITCH_W-1:0]   pitch_deg;
    logic signed [ata_pkg::ROLL_W-1:0]    roll_deg;

    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  calm = 1'b0;
    logic [ata_pkg::GAIN_W-1:0] tb_gain = ata_pkg::GAIN_RESET;

    localparam int LATENCY = 53;
    localparam int WATCHDOG_LIMIT = 2000;

    always #6 clk = ~clk;

    accel_tilt_angles u_dut (
        .clk(clk), .rst_n(rst_n), .gain_we(gain_we), .gain_wdata(gain_wdata),
        .sample_valid(sample_valid), .sample_stall(sample_stall),
        .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
        .result_valid(result_valid), .result_stall(result_stall),
        .magnitude(magnitude), .pitch_deg(pitch_deg), .roll_deg(roll_deg)
    );

    task automatic report(input string what, input longint got, input longint exp_v);
        mismatches++;
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, exp_v, $realtime);
    endtask

    function automatic longint signed sample_ext(logic [15:0] v);
        logic [ata_pkg::SAMPLE_WIDTH-1:0] t;
        t = v[ata_pkg::SAMPLE_WIDTH-1:0];
        return longint'($signed(t));
    endfunction

    function automatic longint unsigned int_root(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint signed angle_deg(longint signed y, longint signed x);
        longint signed acc, nx, ny, dx, dy;
        acc = 0;
        if (y == 0)
            return (x < 0) ? 64'sd3019898880 : 0;
        if (x == 0)
            return (y > 0) ? 64'sd1509949440 : -64'sd1509949440;
        if (x < 0)
        begin
            if (y > 0)
            begin
                nx = y;
                ny = -x;
                acc = 64'sd1509949440;
            end
            else
            begin
                nx = -y;
                ny = x;
                acc = -64'sd1509949440;
            end
            x = nx;
            y = ny;
        end
        for (int i = 0; i < ata_pkg::ANGLE_ITERATIONS && i < ata_pkg::TABLE_LEN; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x += dx;
                y -= dy;
                acc += longint'(ata_pkg::ATAN_TAB[i]);
            end
            else if (y < 0)
            begin
                x -= dx;
                y += dy;
                acc -= longint'(ata_pkg::ATAN_TAB[i]);
            end
        end
        return acc;
    endfunction

    function automatic longint signed round_q8(longint signed a, longint signed lim);
        longint signed r;
        if (a >= 0) r = (a + 32768) >>> 16;
        else r = -((-a + 32768) >>> 16);
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic tilt_t predict_tilt(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                                           logic [ata_pkg::GAIN_W-1:0] g);
        longint signed sx, sy, sz, ryz;
        longint unsigned ax, ay, az, syz, m;
        tilt_t t;
        sx = sample_ext(x) * longint'(g);
        sy = sample_ext(y) * longint'(g);
        sz = sample_ext(z) * longint'(g);
        ax = (sx < 0) ? -sx : sx;
        ay = (sy < 0) ? -sy : sy;
        az = (sz < 0) ? -sz : sz;
        syz = ay * ay + az * az;
        m = (int_root(syz + ax * ax) + 128) >> 8;
        if (m > ata_pkg::MAG_MAX) m = ata_pkg::MAG_MAX;
        ryz = longint'(int_root(syz));
        t.mag = m[ata_pkg::MAG_W-1:0];
        t.pitch = ata_pkg::PITCH_W'(round_q8(angle_deg(sx, ryz), 23040));
        t.roll = ata_pkg::ROLL_W'(round_q8(angle_deg(sy, sz), 46080));
        return t;
    endfunction

    class tilt_scoreboard;
        tilt_t pending[$];
        int checked = 0;

        function void note_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                                  logic [ata_pkg::GAIN_W-1:0] g);
            pending.push_back(predict_tilt(x, y, z, g));
        endfunction

        task check_result(tilt_t got);
            tilt_t e;
            if (pending.size() == 0)
            begin
                report("unexpected item", got.mag, 0);
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.mag !== e.mag) report("magnitude", got.mag, e.mag);
            if (got.pitch !== e.pitch) report("pitch_deg", got.pitch, e.pitch);
            if (got.roll !== e.roll) report("roll_deg", got.roll, e.roll);
        endtask
    endclass

    tilt_scoreboard sb = new();

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_valid && !sample_stall)
                sb.note_sample(accel_x, accel_y, accel_z, tb_gain);
            if (result_valid && !result_stall)
                sb.check_result('{magnitude, pitch_deg, roll_deg});
            if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // hold the result side in random stall bursts
    initial
    begin
        int n;
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 7);
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    task automatic write_gain(input logic [ata_pkg::GAIN_W-1:0] g);
        gain_we <= 1'b1;
        gain_wdata <= g;
        @(posedge clk);
        gain_we <= 1'b0;
        tb_gain = g;
    endtask

    task automatic send_sample(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 7);
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        accel_x <= x;
        accel_y <= y;
        accel_z <= z;
        do @(posedge clk); while (sample_stall);
    endtask

    task automatic drain();
        sample_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed($urandom_range(0, 64)) - 32);
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++)
            send_sample(rand_axis(), rand_axis(), rand_axis());
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_sample(16'sd0, 16'sd0, 16'sd0);
        send_sample(16'sd0, 16'sd0, 16'sd1000);
        send_sample(16'sd0, 16'sd0, -16'sd1000);
        send_sample(16'sd0, 16'sd1000, 16'sd0);
        send_sample(16'sd0, -16'sd1000, 16'sd0);
        send_sample(16'sd1000, 16'sd0, 16'sd0);
        send_sample(-16'sd1000, 16'sd0, 16'sd0);
        send_sample(16'h7fff, 16'h7fff, 16'h7fff);
        send_sample(16'h8000, 16'h8000, 16'h8000);
        send_sample(16'h8000, 16'h7fff, 16'h8000);
        send_sample(16'sd1, -16'sd1, -16'sd1);
        send_sample(16'sd100, 16'sd100, 16'sd100);
        send_sample(-16'sd5, 16'sd3, -16'sd7);
        drain();

        write_gain(16'hffff);
        send_sample(16'h8000, 16'h8000, 16'h8000);
        send_sample(16'h7fff, 16'h8000, 16'h7fff);
        run_random(200);
        drain();

        write_gain(16'h0000);
        send_sample(16'h1234, 16'h8000, 16'h7fff);
        run_random(50);
        drain();

        write_gain(16'h0001);
        run_random(200);
        drain();

        write_gain(16'($urandom()));
        run_random(300);
        drain();

        write_gain(ata_pkg::GAIN_RESET);
        run_random(400);
        calm = 1'b1;
        run_random(130);
        drain();

        $display("covered %0d results over gains 0, 1, max, reset and a random one",
                 sb.checked);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("watchdog expired with %0d items outstanding", sb.pending.size());
        $display("FAILED: results differ");
        $finish;
    end
endmodule

>>> files.f
rtl/ata_pkg.sv
rtl/ata_isqrt.sv
rtl/ata_cordic.sv
rtl/accel_tilt_angles.sv
dv/tb.sv
